FILE: rtl/rtc_slew_recheck_policy_top_defines.svh
// assertion macros for the rtc slew recheck policy block
// used by rtc_slew_recheck_policy_top and rsrp_div; expects clk and arst_n in scope
`ifndef RTC_SLEW_RECHECK_POLICY_TOP_DEFINES_SVH
`define RTC_SLEW_RECHECK_POLICY_TOP_DEFINES_SVH

// same-cycle implication, off while in reset
`define RSRP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define RSRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rsrp_pkg.sv
// shared constants and types for the rtc slew recheck policy block
// no dependencies
`default_nettype none

package rsrp_pkg;

	localparam int unsigned SEC_W = 32;
	localparam int unsigned DIV_W = SEC_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

	// seconds from 1900-01-01 to 1970-01-01
	localparam logic [SEC_W-1:0] EPOCH_1900_TO_1970 = 32'd2208988800;

	// register reset values
	localparam logic [SEC_W-1:0] RECHECK_RESET = 32'd86400;
	localparam logic [SEC_W-1:0] MAX_OFFSET_RESET = 32'd86400;
	localparam logic [SEC_W-1:0] SYNC_WINDOW_RESET = 32'd3600;
	localparam logic [SEC_W-1:0] MIN_RECHECK_RESET = 32'd100;

	// register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_WINDOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RECHECK = 2'd2;

	// status codes
	localparam logic [1:0] ST_COMPARED = 2'd0;
	localparam logic [1:0] ST_TOO_FAR = 2'd1;
	localparam logic [1:0] ST_NO_RESPONSE = 2'd2;

	// rtc step codes
	localparam logic signed [1:0] STEP_NONE = 2'sb00;
	localparam logic signed [1:0] STEP_PLUS = 2'sb01;
	localparam logic signed [1:0] STEP_MINUS = 2'sb11;

	// divider control and status
	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/rsrp_if.sv
// valid/ready channel interfaces for query requests and result requests
// no dependencies
`default_nettype none

interface rsrp_query_if;
	logic valid;
	logic ready;
	logic response_ok;
	logic [31:0] server_seconds;
	logic [31:0] local_rtc_seconds;

	modport source (output valid, output response_ok, output server_seconds,
		output local_rtc_seconds, input ready);
	modport sink (input valid, input response_ok, input server_seconds,
		input local_rtc_seconds, output ready);
endinterface

interface rsrp_result_if;
	logic valid;
	logic ready;
	logic signed [1:0] rtc_step;
	logic [1:0] status;
	logic [31:0] wake_time;
	logic [31:0] recheck_interval;

	modport source (output valid, output rtc_step, output status, output wake_time,
		output recheck_interval, input ready);
	modport sink (input valid, input rtc_step, input status, input wake_time,
		input recheck_interval, output ready);
endinterface

`default_nettype wire

FILE: rtl/rsrp_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on rsrp_pkg and rtc_slew_recheck_policy_top_defines.svh
`default_nettype none

`include "rtc_slew_recheck_policy_top_defines.svh"

module rsrp_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire rsrp_pkg::div_ctrl_t ctrl,
	input wire logic [rsrp_pkg::DIV_W-1:0] dividend,
	input wire logic [rsrp_pkg::DIV_W-1:0] divisor,
	output rsrp_pkg::div_stat_t stat,
	output logic [rsrp_pkg::DIV_W-1:0] quotient
);
	import rsrp_pkg::*;

	localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_W - 1);

	logic busy_q;
	logic done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dvs_q;
	logic [DIV_W:0] shifted;
	logic [DIV_W:0] trial;

	// one trial subtract per cycle
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial = shifted - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= trial[DIV_W] ? shifted[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ~trial[DIV_W]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient = quo_q;

	`RSRP_ASSERT_NOW(a_start_when_idle, ctrl.start, !busy_q, "divider started while busy")
	`RSRP_ASSERT_NOW(a_done_after_busy, done_q, $past(busy_q), "done without a running divide")
	`RSRP_ASSERT_NOW(a_done_not_busy, done_q, !busy_q, "done while still busy")

endmodule

`default_nettype wire

FILE: rtl/rtc_slew_recheck_policy_top.sv
// path: accept, difference, magnitude, classify, done, output register; a recomputed
// recheck interval adds the 32-step serial divider and the clamp and update states
// throughput: one request at a time; a new request is taken once the previous result
// sits in the output register
// reset: asynchronous, restores register defaults and a one-day recheck interval
// depends on rsrp_pkg, rsrp_if, rsrp_div and rtc_slew_recheck_policy_top_defines.svh
`default_nettype none

`include "rtc_slew_recheck_policy_top_defines.svh"

module rtc_slew_recheck_policy_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [rsrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [rsrp_pkg::SEC_W-1:0] cfg_data,
	rsrp_query_if.sink query,
	rsrp_result_if.source result
);
	import rsrp_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIFF = 3'd1;
	localparam logic [2:0] S_MAG = 3'd2;
	localparam logic [2:0] S_CLASS = 3'd3;
	localparam logic [2:0] S_DIV = 3'd4;
	localparam logic [2:0] S_CLAMP = 3'd5;
	localparam logic [2:0] S_UPD = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q;
	logic ok_q;
	logic [SEC_W-1:0] server_q;
	logic [SEC_W-1:0] local_q;
	logic [SEC_W-1:0] diff_q;
	logic [SEC_W-1:0] mag_q;
	logic [SEC_W-1:0] dur_q;
	logic signed [1:0] step_q;
	logic [1:0] status_q;
	logic [SEC_W-1:0] max_offset_q;
	logic [SEC_W-1:0] sync_window_q;
	logic [SEC_W-1:0] min_recheck_q;
	logic [SEC_W-1:0] recheck_q;

	logic ovalid_q;
	logic signed [1:0] ostep_q;
	logic [1:0] ostatus_q;
	logic [SEC_W-1:0] owake_q;
	logic [SEC_W-1:0] orecheck_q;

	logic [SEC_W:0] grow_sum;
	logic [SEC_W-1:0] grown;
	logic out_load;
	div_ctrl_t div_ctrl;
	div_stat_t div_stat;
	logic [SEC_W-1:0] div_quo;

	// interval grows by half, saturating
	assign grow_sum = {1'b0, recheck_q} + {2'b00, recheck_q[SEC_W-1:1]};
	assign grown = grow_sum[SEC_W] ? '1 : grow_sum[SEC_W-1:0];

	assign query.ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_DONE) && (!ovalid_q || result.ready);

	// divider start when the error needs a new interval
	assign div_ctrl.start = (state_q == S_CLASS) && ok_q && (mag_q <= max_offset_q)
		&& (mag_q > SEC_W'(1));

	rsrp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(div_ctrl),
		.dividend(sync_window_q),
		.divisor(mag_q - SEC_W'(1)),
		.stat(div_stat),
		.quotient(div_quo)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_offset_q <= MAX_OFFSET_RESET;
			sync_window_q <= SYNC_WINDOW_RESET;
			min_recheck_q <= MIN_RECHECK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_OFFSET: max_offset_q <= cfg_data;
				REG_SYNC_WINDOW: sync_window_q <= cfg_data;
				REG_MIN_RECHECK: min_recheck_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and recheck interval
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			recheck_q <= RECHECK_RESET;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (query.valid) state_q <= S_DIFF;
				end
				S_DIFF: state_q <= S_MAG;
				S_MAG: state_q <= S_CLASS;
				S_CLASS: begin
					if (div_ctrl.start) begin
						state_q <= S_DIV;
					end else begin
						if (ok_q && (mag_q <= max_offset_q) && (mag_q == '0))
							recheck_q <= grown;
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (div_stat.done) state_q <= S_CLAMP;
				end
				S_CLAMP: state_q <= S_UPD;
				S_UPD: begin
					if (recheck_q > dur_q) recheck_q <= dur_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (query.valid && query.ready) begin
			ok_q <= query.response_ok;
			server_q <= query.server_seconds;
			local_q <= query.local_rtc_seconds;
		end
		if (state_q == S_DIFF)
			diff_q <= server_q - EPOCH_1900_TO_1970 - local_q;
		if (state_q == S_MAG)
			mag_q <= diff_q[SEC_W-1] ? ('0 - diff_q) : diff_q;
		if (state_q == S_CLASS) begin
			priority if (!ok_q) begin
				status_q <= ST_NO_RESPONSE;
				step_q <= STEP_NONE;
			end else if (mag_q > max_offset_q) begin
				status_q <= ST_TOO_FAR;
				step_q <= STEP_NONE;
			end else begin
				status_q <= ST_COMPARED;
				if (mag_q != '0) step_q <= diff_q[SEC_W-1] ? STEP_MINUS : STEP_PLUS;
				else step_q <= STEP_NONE;
			end
		end
		if ((state_q == S_DIV) && div_stat.done)
			dur_q <= div_quo;
		if ((state_q == S_CLAMP) && (dur_q < min_recheck_q))
			dur_q <= min_recheck_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (result.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ostep_q <= step_q;
			ostatus_q <= status_q;
			owake_q <= local_q + recheck_q;
			orecheck_q <= recheck_q;
		end
	end

	assign result.valid = ovalid_q;
	assign result.rtc_step = ostep_q;
	assign result.status = ostatus_q;
	assign result.wake_time = owake_q;
	assign result.recheck_interval = orecheck_q;

	`RSRP_ASSERT_NOW(a_no_step_unless_compared, ovalid_q && (ostatus_q != ST_COMPARED), ostep_q == STEP_NONE, "step reported without a comparison")
	`RSRP_ASSERT_NOW(a_div_done_in_div, div_stat.done, state_q == S_DIV, "divider finished outside divide state")
	`RSRP_ASSERT_NEXT(a_accept_starts_work, query.valid && query.ready, state_q == S_DIFF, "accepted request did not start")
	`RSRP_ASSERT_NOW(a_ready_divider_idle, query.ready, !div_stat.busy, "ready while divider busy")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// testbench for rtc_slew_recheck_policy_top: a directed table of query requests, then random phases
// under several register settings; results checked against table values or an in-bench model
// depends on rsrp_pkg, rsrp_if and the rtc_slew_recheck_policy_top rtl
module tb_top;
	import rsrp_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_CYCLES = 150;
	localparam int HOLD_AFTER = 300;
	localparam int DRAIN_CYCLES = 45;
	localparam int N_DIRECTED = 23;

	typedef struct packed {
		logic signed [1:0] step;
		logic [1:0] status;
		logic [31:0] wake;
		logic [31:0] interval;
	} verdict_t;

	typedef struct packed {
		logic ok;
		logic [31:0] server;
		logic [31:0] rtc;
		logic known;
		verdict_t want;
	} query_t;

	localparam verdict_t UNTYPED = '0;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SEC_W-1:0] cfg_data;

	rsrp_query_if query_ch();
	rsrp_result_if result_ch();

	rtc_slew_recheck_policy_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.query(query_ch),
		.result(result_ch)
	);

	// policy model: registers and the recheck interval
	logic [31:0] max_offset;
	logic [31:0] sync_window;
	logic [31:0] min_recheck;
	logic [31:0] recheck;

	verdict_t awaited_verdicts[$];
	int errors = 0;
	int results_seen = 0;
	int idle_pct = 0;
	int stale_cycles = 0;
	query_t plan [N_DIRECTED];

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// server reading that gives the wanted error against the local rtc
	function automatic logic [31:0] server_for(logic [31:0] rtc, logic [31:0] err);
		return rtc + EPOCH_1900_TO_1970 + err;
	endfunction

	// expected result of one query, advances the model interval
	function automatic verdict_t apply_policy(query_t q);
		verdict_t v;
		logic [31:0] err;
		logic [31:0] mag;
		logic [31:0] dur;
		logic [31:0] half;
		v.step = STEP_NONE;
		if (!q.ok) begin
			v.status = ST_NO_RESPONSE;
		end else begin
			err = q.server - EPOCH_1900_TO_1970 - q.rtc;
			mag = err[31] ? -err : err;
			if (mag > max_offset) begin
				v.status = ST_TOO_FAR;
			end else begin
				v.status = ST_COMPARED;
				if (mag == 32'd0) begin
					// grow by half, saturating
					half = recheck >> 1;
					if (recheck > 32'hFFFF_FFFF - half) begin
						recheck = 32'hFFFF_FFFF;
					end else begin
						recheck = recheck + half;
					end
				end else begin
					// shorten so the error is slewed away within the window
					if (mag != 32'd1) begin
						dur = sync_window / (mag - 32'd1);
						if (dur < min_recheck) begin
							dur = min_recheck;
						end
						if (recheck > dur) begin
							recheck = dur;
						end
					end
					v.step = err[31] ? STEP_MINUS : STEP_PLUS;
				end
			end
		end
		v.wake = q.rtc + recheck;
		v.interval = recheck;
		return v;
	endfunction

	// random query, weighted toward errors the policy corrects
	function automatic query_t random_query(bit zero_err);
		query_t q;
		logic [31:0] err;
		logic [31:0] mag;
		int unsigned pick;
		q = '0;
		q.ok = 1'b1;
		pick = zero_err ? 30 : $urandom_range(0, 99);
		case ($urandom_range(0, 15))
			0: q.rtc = '0;
			1: q.rtc = '1;
			default: q.rtc = $urandom;
		endcase
		if (pick < 20) begin
			// no response, or an arbitrary server reading
			q.ok = (pick >= 8);
			q.server = $urandom;
		end else begin
			if (pick < 45) begin
				mag = 32'd0;
			end else if (pick < 58) begin
				mag = 32'd1;
			end else if (pick < 75) begin
				mag = $urandom_range(2, 64);
			end else if (pick < 88) begin
				mag = $urandom_range(2, max_offset);
			end else begin
				mag = max_offset + $urandom_range(0, 1);
			end
			err = $urandom_range(0, 1) ? -mag : mag;
			q.server = server_for(q.rtc, err);
		end
		return q;
	endfunction

	// offer one query request, record its expected result on accept
	task automatic offer_query(query_t q);
		verdict_t v;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			query_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		query_ch.valid <= 1'b1;
		query_ch.response_ok <= q.ok;
		query_ch.server_seconds <= q.server;
		query_ch.local_rtc_seconds <= q.rtc;
		do @(posedge clk); while (!query_ch.ready);
		v = apply_policy(q);
		awaited_verdicts.push_back(q.known ? q.want : v);
	endtask

	task automatic wait_drained();
		while (awaited_verdicts.size() != 0) @(posedge clk);
	endtask

	// write all three registers back to back
	task automatic set_registers(logic [31:0] offset, logic [31:0] window, logic [31:0] floor_s);
		logic [31:0] vals [3];
		logic [CFG_IDX_W-1:0] idx [3];
		vals = '{offset, window, floor_s};
		idx = '{REG_MAX_OFFSET, REG_SYNC_WINDOW, REG_MIN_RECHECK};
		for (int i = 0; i < 3; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		max_offset = offset;
		sync_window = window;
		min_recheck = floor_s;
	endtask

	// one register setting followed by random queries, zero-error streaks now and then
	task automatic run_phase(logic [31:0] offset, logic [31:0] window, logic [31:0] floor_s,
		int count, int pct);
		int sent;
		int streak;
		wait_drained();
		repeat (4) @(posedge clk);
		set_registers(offset, window, floor_s);
		idle_pct = pct;
		sent = 0;
		streak = 0;
		while (sent < count) begin
			if (streak == 0 && $urandom_range(0, 39) == 0) begin
				streak = $urandom_range(20, 60);
			end
			offer_query(random_query(streak != 0));
			if (streak != 0) begin
				streak--;
			end
			sent++;
		end
		query_ch.valid <= 1'b0;
	endtask

	// stimulus
	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		query_ch.valid <= 1'b0;
		query_ch.response_ok <= 1'b0;
		query_ch.server_seconds <= '0;
		query_ch.local_rtc_seconds <= '0;
		max_offset = MAX_OFFSET_RESET;
		sync_window = SYNC_WINDOW_RESET;
		min_recheck = MIN_RECHECK_RESET;
		recheck = RECHECK_RESET;

		// directed table, run under reset settings
		plan = '{
			// no response at the field extremes
			'{1'b0, 32'd0, 32'd0, 1'b1,
				'{STEP_NONE, ST_NO_RESPONSE, 32'd86400, 32'd86400}},
			'{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
				'{STEP_NONE, ST_NO_RESPONSE, 32'd86399, 32'd86400}},
			// just beyond the offset limit, both signs, and the most negative error
			'{1'b1, server_for(32'd1000, 32'd86401), 32'd1000, 1'b1,
				'{STEP_NONE, ST_TOO_FAR, 32'd87400, 32'd86400}},
			'{1'b1, server_for(32'd5000, -32'd86401), 32'd5000, 1'b1,
				'{STEP_NONE, ST_TOO_FAR, 32'd91400, 32'd86400}},
			'{1'b1, server_for(32'd0, 32'h8000_0000), 32'd0, 1'b1,
				'{STEP_NONE, ST_TOO_FAR, 32'd86400, 32'd86400}},
			// one second either way: step only
			'{1'b1, server_for(32'd7, 32'd1), 32'd7, 1'b1,
				'{STEP_PLUS, ST_COMPARED, 32'd86407, 32'd86400}},
			'{1'b1, server_for(32'hFFFF_FFFF, -32'd1), 32'hFFFF_FFFF, 1'b1,
				'{STEP_MINUS, ST_COMPARED, 32'd86399, 32'd86400}},
			// zero error grows the interval by half
			'{1'b1, server_for(32'd200, 32'd0), 32'd200, 1'b1,
				'{STEP_NONE, ST_COMPARED, 32'd129800, 32'd129600}},
			// error right at the limit, clamped to the minimum interval
			'{1'b1, server_for(32'd0, 32'd86400), 32'd0, 1'b1,
				'{STEP_PLUS, ST_COMPARED, 32'd100, 32'd100}},
			'{1'b1, server_for(32'd0, -32'd86400), 32'd0, 1'b1,
				'{STEP_MINUS, ST_COMPARED, 32'd100, 32'd100}},
			// raw field extremes with a response
			'{1'b1, 32'd0, 32'd0, 1'b0, UNTYPED},
			'{1'b1, 32'hFFFF_FFFF, 32'd0, 1'b0, UNTYPED},
			'{1'b1, 32'd0, 32'hFFFF_FFFF, 1'b0, UNTYPED},
			'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, UNTYPED},
			// growth from the minimum, then shortening by the window
			'{1'b1, server_for(32'd300, 32'd0), 32'd300, 1'b0, UNTYPED},
			'{1'b1, server_for(32'd301, 32'd0), 32'd301, 1'b0, UNTYPED},
			'{1'b1, server_for(32'd302, 32'd0), 32'd302, 1'b0, UNTYPED},
			'{1'b1, server_for(32'd303, 32'd0), 32'd303, 1'b0, UNTYPED},
			'{1'b1, server_for(32'd40, 32'd2), 32'd40, 1'b0, UNTYPED},
			'{1'b1, server_for(32'd12345, -32'd37), 32'd12345, 1'b0, UNTYPED},
			'{1'b1, server_for(32'd9, 32'd10), 32'd9, 1'b0, UNTYPED},
			'{1'b0, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 1'b0, UNTYPED},
			'{1'b1, server_for(32'd1, 32'd0), 32'd1, 1'b0, UNTYPED}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 25;
		foreach (plan[i]) begin
			offer_query(plan[i]);
		end
		query_ch.valid <= 1'b0;

		// register settings, extremes included; the last phase runs with no idling
		run_phase(MAX_OFFSET_RESET, SYNC_WINDOW_RESET, MIN_RECHECK_RESET, 380, 25);
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 300, 50);
		run_phase(32'd0, 32'd1, 32'hFFFF_FFFF, 300, 0);
		run_phase($urandom, $urandom_range(1, 32'hFFFF_FFFF), $urandom_range(1, 5000), 300, 10);
		run_phase(32'd1000, 32'd86400, 32'd60, 300, 30);
		run_phase($urandom_range(0, 500000), $urandom_range(1, 1000000),
			$urandom_range(1, 2000), 300, 0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && awaited_verdicts.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// result sink: random stall bursts, one long hold-off to back the block up
	initial begin : result_sink
		bit held;
		held = 1'b0;
		result_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// check each result request against the oldest expectation
	always @(posedge clk) begin : result_check
		verdict_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (awaited_verdicts.size() == 0) begin
				$error("result with no query pending: status %0d, wake_time %0d",
					result_ch.status, result_ch.wake_time);
				errors++;
			end else begin
				want = awaited_verdicts.pop_front();
				compare_field("rtc_step", want.step, result_ch.rtc_step);
				compare_field("status", want.status, result_ch.status);
				compare_field("wake_time", want.wake, result_ch.wake_time);
				compare_field("recheck_interval", want.interval, result_ch.recheck_interval);
			end
		end
	end

	// watchdog on cycles with no request moving on either side
	always @(posedge clk) begin
		if (!arst_n || (query_ch.valid && query_ch.ready)
			|| (result_ch.valid && result_ch.ready)) begin
			stale_cycles <= 0;
		end else if (stale_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stale_cycles <= stale_cycles + 1;
		end
	end

endmodule
